/* hw/rtl/lzodm_pkg.sv */
package lzodm_pkg;

    // ray count limits
    localparam int unsigned MAX_RAYS = 1024;
    localparam int unsigned MIN_RAYS = 5;
    localparam int unsigned NUM_ZONES = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_RAYS_PER_SCAN     = 2'd0;
    localparam logic [1:0] CFG_MAX_RANGE         = 2'd1;
    localparam logic [1:0] CFG_OBSTACLE_DISTANCE = 2'd2;

    // configuration reset values
    localparam logic [10:0] RAYS_PER_SCAN_RESET     = 11'd720;
    localparam logic [15:0] MAX_RANGE_RESET         = 16'd3500;
    localparam logic [15:0] OBSTACLE_DISTANCE_RESET = 16'd500;

    // drive modes
    localparam logic [2:0] MODE_FIND_WALL    = 3'd0;
    localparam logic [2:0] MODE_TURN_LEFT    = 3'd1;
    localparam logic [2:0] MODE_FOLLOW       = 3'd2;
    localparam logic [2:0] MODE_SLOW_AHEAD   = 3'd3;
    localparam logic [2:0] MODE_REVERSE_LEFT = 3'd4;

    // drive mode for each blocked-zone pattern
    localparam logic [2:0] MODE_OF_MASK [32] = '{
        MODE_FIND_WALL,  MODE_FOLLOW,     MODE_TURN_LEFT,  MODE_TURN_LEFT,
        MODE_TURN_LEFT,  MODE_TURN_LEFT,  MODE_TURN_LEFT,  MODE_TURN_LEFT,
        MODE_FIND_WALL,  MODE_SLOW_AHEAD, MODE_SLOW_AHEAD, MODE_SLOW_AHEAD,
        MODE_TURN_LEFT,  MODE_TURN_LEFT,  MODE_TURN_LEFT,  MODE_TURN_LEFT,
        MODE_FIND_WALL,  MODE_SLOW_AHEAD, MODE_SLOW_AHEAD, MODE_TURN_LEFT,
        MODE_FIND_WALL,  MODE_TURN_LEFT,  MODE_FIND_WALL,  MODE_TURN_LEFT,
        MODE_FIND_WALL,  MODE_FIND_WALL,  MODE_SLOW_AHEAD, MODE_SLOW_AHEAD,
        MODE_TURN_LEFT,  MODE_FIND_WALL,  MODE_TURN_LEFT,  MODE_REVERSE_LEFT
    };

    // forward speed of a mode, mm/s
    function automatic logic signed [9:0] lin_of_mode(input logic [2:0] mode);
        logic signed [9:0] lin;
        case (mode)
            MODE_FIND_WALL:    lin = 10'sd150;
            MODE_TURN_LEFT:    lin = 10'sd0;
            MODE_FOLLOW:       lin = 10'sd150;
            MODE_SLOW_AHEAD:   lin = 10'sd100;
            MODE_REVERSE_LEFT: lin = -10'sd500;
            default:           lin = 10'sd0;
        endcase
        return lin;
    endfunction

    // turn rate of a mode, mrad/s
    function automatic logic signed [8:0] ang_of_mode(input logic [2:0] mode);
        logic signed [8:0] ang;
        case (mode)
            MODE_FIND_WALL:    ang = -9'sd150;
            MODE_TURN_LEFT:    ang = 9'sd200;
            MODE_FOLLOW:       ang = 9'sd0;
            MODE_SLOW_AHEAD:   ang = 9'sd0;
            MODE_REVERSE_LEFT: ang = 9'sd200;
            default:           ang = 9'sd0;
        endcase
        return ang;
    endfunction

    // first ray of zone k: floor(k*n/5), via reciprocal 3277/2^14 (exact up to 4*MAX_RAYS)
    function automatic logic [10:0] zone_bound(input logic [2:0] k, input logic [10:0] n);
        logic [12:0] x;
        logic [24:0] p;
        x = 13'({10'd0, k} * {2'd0, n});
        p = {12'd0, x} * 25'd3277;
        return p[24:14];
    endfunction

endpackage

/* hw/rtl/lidar_zone_obstacle_drive_mode.sv */
// lidar zone obstacle detector and drive-mode selector
//
// s_* carries one lidar range sample (mm) per item, rays ordered right to left.
// each scan of rays_per_scan rays (clamped to 5..1024) is split into five equal
// angular zones; the block keeps the minimum of each zone over the scan.
// on the last ray of a scan one item leaves on m_*: the drive mode picked from
// the blocked-zone pattern, its speed commands, the pattern and a held flag.
// other rays give no output item.
// cfg_* writes rays_per_scan, max_range and obstacle_distance (index 0..2);
// always ready, to be written only while the block is idle.
// timing: one item per cycle while the output is not stalled; the zone minimum fold, threshold
// compare and mode lookup all sit between the accepted sample and the output
// register, so the result is valid in the cycle after the last ray is accepted.
// reset clears the ray index (next item starts a scan), restores the register
// defaults and sets the mode to find wall.
// a stalled receiver holds the output item; while it waits no sample is taken,
// so s_tready stays low until the receiver takes the item.
module lidar_zone_obstacle_drive_mode
    import lzodm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] range_mm
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [2:0] drive_mode, [12:3] linear_speed,
                                    // [21:13] angular_rate, [26:22] blocked_mask, zero fill
    output logic [0:0]  m_tuser,    // [0] mode_held
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [10:0] rays_per_scan_reg;
    logic [15:0] max_range_reg;
    logic [15:0] obstacle_distance_reg;
    logic [15:0] zone_min_reg [NUM_ZONES];
    logic [15:0] zone_min_next [NUM_ZONES];
    logic [9:0]  ray_index_reg;
    logic [9:0]  ray_index_next;
    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;

    logic        out_valid_reg;
    logic [2:0]  out_mode_reg;
    logic [4:0]  out_mask_reg;
    logic        out_held_reg;

    logic        in_fire;
    logic [10:0] n_eff;
    logic [9:0]  n_last;
    logic [9:0]  ray_cur;
    logic        last_ray;
    logic [2:0]  zone;
    logic [4:0]  mask;
    logic        held;
    logic [15:0] zone_base;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    // effective ray count and current ray position
    always_comb
    begin
        if (rays_per_scan_reg < 11'(MIN_RAYS))
            n_eff = 11'(MIN_RAYS);
        else if (rays_per_scan_reg > 11'(MAX_RAYS))
            n_eff = 11'(MAX_RAYS);
        else
            n_eff = rays_per_scan_reg;
        n_last   = 10'(n_eff - 11'd1);
        last_ray = ray_index_reg >= n_last;
        ray_cur  = last_ray ? n_last : ray_index_reg;
    end

    // zone of the current ray: count of zone starts at or below it
    always_comb
    begin
        zone = 3'd0;
        for (int k = 1; k < NUM_ZONES; k++)
        begin
            if ({1'b0, ray_cur} >= zone_bound(3'(k), n_eff))
                zone = zone + 3'd1;
        end
    end

    // fold sample into zone minima, compare against threshold
    always_comb
    begin
        mask = '0;
        held = 1'b0;
        zone_base = '0;
        for (int k = 0; k < NUM_ZONES; k++)
        begin
            zone_base = (ray_cur == 10'd0) ? max_range_reg : zone_min_reg[k];
            if (zone == 3'(k) && s_tdata < zone_base)
                zone_min_next[k] = s_tdata;
            else
                zone_min_next[k] = zone_base;
            if (zone_min_next[k] < obstacle_distance_reg)
                mask[k] = 1'b1;
            else if (zone_min_next[k] == obstacle_distance_reg)
                held = 1'b1;
        end
        mode_next      = held ? mode_reg : MODE_OF_MASK[mask];
        ray_index_next = last_ray ? 10'd0 : ray_cur + 10'd1;
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rays_per_scan_reg     <= RAYS_PER_SCAN_RESET;
            max_range_reg         <= MAX_RANGE_RESET;
            obstacle_distance_reg <= OBSTACLE_DISTANCE_RESET;
            ray_index_reg         <= '0;
            mode_reg              <= MODE_FIND_WALL;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RAYS_PER_SCAN:     rays_per_scan_reg     <= cfg_data[10:0];
                    CFG_MAX_RANGE:         max_range_reg         <= cfg_data;
                    CFG_OBSTACLE_DISTANCE: obstacle_distance_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (in_fire)
            begin
                ray_index_reg <= ray_index_next;
                if (last_ray)
                    mode_reg <= mode_next;
            end
            if (in_fire && last_ray)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // zone minima and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < NUM_ZONES; k++)
                zone_min_reg[k] <= zone_min_next[k];
            if (last_ray)
            begin
                out_mode_reg <= mode_next;
                out_mask_reg <= mask;
                out_held_reg <= held;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_mask_reg, ang_of_mode(out_mode_reg),
                       lin_of_mode(out_mode_reg), out_mode_reg};
    assign m_tuser  = out_held_reg;

    // a closing ray always leaves an output item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_ray |=> m_tvalid)
        else $error("closing ray gave no output item");

    // a fresh decision follows the mode table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[2:0] == MODE_OF_MASK[m_tdata[26:22]])
        else $error("drive mode does not match blocked pattern");

    // a held decision repeats the kept mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[2:0] == mode_reg)
        else $error("held mode differs from kept mode");

    // mode register stays a valid mode
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= MODE_REVERSE_LEFT)
        else $error("mode register out of range");

    // ray index does not wrap to zero inside a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !last_ray |=> ray_index_reg != 10'd0)
        else $error("ray index wrapped inside a scan");

endmodule
